/* hw/rtl/owtm_pkg.sv */
`timescale 1ns / 1ps

package owtm_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_TEMP  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [2:0] CFG_RESET_REL    = 3'd1;
  localparam logic [2:0] CFG_PRES_RECOVER = 3'd2;
  localparam logic [2:0] CFG_SLOT_LOW     = 3'd3;
  localparam logic [2:0] CFG_WRITE_HOLD   = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE  = 3'd5;
  localparam logic [2:0] CFG_READ_RECOVER = 3'd6;
  localparam logic [2:0] CFG_CONV_WAIT    = 3'd7;

  localparam int unsigned CfgDataW = 20;
  localparam int unsigned TickW    = 20;

  // register reset values
  localparam logic [9:0]  RESET_LOW_DEF    = 10'd700;
  localparam logic [7:0]  RESET_REL_DEF    = 8'd60;
  localparam logic [9:0]  PRES_RECOVER_DEF = 10'd500;
  localparam logic [3:0]  SLOT_LOW_DEF     = 4'd2;
  localparam logic [7:0]  WRITE_HOLD_DEF   = 8'd60;
  localparam logic [3:0]  READ_SAMPLE_DEF  = 4'd2;
  localparam logic [7:0]  READ_RECOVER_DEF = 8'd70;
  localparam logic [19:0] CONV_WAIT_DEF    = 20'd20000;

  // rom and function commands sent during the temperature read
  localparam logic [7:0] ROM_SKIP      = 8'hCC;
  localparam logic [7:0] FN_CONVERT    = 8'h44;
  localparam logic [7:0] FN_READ_SCRAT = 8'hBE;

  // last step of the temperature read sequence, and the step that reads the low byte
  localparam logic [3:0] SEQ_LAST = 4'd8;
  localparam logic [3:0] SEQ_LOW_BYTE = 4'd7;

  typedef enum logic [1:0] {
    KIND_RESET,
    KIND_WRITE,
    KIND_READ,
    KIND_CONV
  } kind_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       line_level;
  } in_word_t;

  typedef struct packed {
    logic        line_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
  } out_word_t;

  function automatic kind_e seq_kind(input logic [3:0] step);
    kind_e k;
    case (step)
      4'd0, 4'd4: k = KIND_RESET;
      4'd1, 4'd2, 4'd5, 4'd6: k = KIND_WRITE;
      4'd3: k = KIND_CONV;
      default: k = KIND_READ;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd1, 4'd5: b = ROM_SKIP;
      4'd2: b = FN_CONVERT;
      4'd6: b = FN_READ_SCRAT;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/one_wire_temperature_master_core.sv */
`timescale 1ns / 1ps

// channel  | signals                          | word
// ---------+----------------------------------+-------------------------------
// in       | in_valid_i / in_ready_o          | in_word_i: one bus tick
// out      | out_valid_o / out_ready_i        | out_word_o: line and status
// cfg      | cfg_we_i, cfg_idx_i, cfg_data_i  | timing register write
//
// one word per cycle while the output is not stalled: each accepted tick is processed in the cycle it is
// accepted and its result lands in the output register on the same edge
// the output register is the only stage; a new tick is taken whenever that
// register is empty or is being emptied, so full rate with out_ready_i high
// reset (rst_ni low, async) clears the sequencer to idle and loads the
// default timings; a stall on the output simply holds in_ready_o low

module one_wire_temperature_master_core
  import owtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_WR_SLOT,
    PH_WR_HOLD,
    PH_RD_SLOT,
    PH_RD_SAMPLE,
    PH_RD_REC,
    PH_CONV
  } phase_e;

  // timing registers
  logic [9:0]  reset_low_q, pres_rec_q;
  logic [7:0]  reset_rel_q, write_hold_q, read_rec_q;
  logic [3:0]  slot_low_q, read_sample_q;
  logic [19:0] conv_wait_q;

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [3:0]      step_q, step_d;
  logic [7:0]      low_q, low_d;
  logic [15:0]     result_q, result_d;
  logic [2:0]      active_q, active_d;

  // output register
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;

  logic in_fire;

  // working values for the tick
  logic [TickW-1:0] dur;
  logic [TickW-1:0] tick_nxt;
  logic             hit;
  logic             line;
  logic             done;
  logic             sub_end;
  logic             fin;
  kind_e            kind;
  logic [7:0]       kbyte;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    step_d   = step_q;
    low_d    = low_q;
    result_d = result_q;
    active_d = active_q;
    line     = 1'b1;
    done     = 1'b0;
    sub_end  = 1'b0;
    fin      = 1'b0;
    kind     = KIND_RESET;
    kbyte    = 8'h00;

    // command start, only when idle; the start tick is the first tick of
    // the first phase
    if (phase_q == PH_IDLE && (in_word_i.command inside {[CMD_RESET:CMD_TEMP]})) begin
      active_d = in_word_i.command;
      step_d   = '0;
      tick_d   = '0;
      bit_d    = '0;
      case (in_word_i.command)
        CMD_WRITE: begin
          shift_d = in_word_i.write_data;
          phase_d = PH_WR_SLOT;
        end
        CMD_READ: begin
          shift_d = '0;
          phase_d = PH_RD_SLOT;
        end
        default: phase_d = PH_RST_LOW; // bus reset, also first step of temp read
      endcase
    end

    // duration of the phase being timed; zero behaves like one
    case (phase_d)
      PH_RST_LOW:   dur = TickW'(reset_low_q);
      PH_RST_REL:   dur = TickW'(reset_rel_q);
      PH_RST_REC:   dur = TickW'(pres_rec_q);
      PH_WR_SLOT:   dur = TickW'(slot_low_q);
      PH_RD_SLOT:   dur = TickW'(slot_low_q);
      PH_WR_HOLD:   dur = TickW'(write_hold_q);
      PH_RD_SAMPLE: dur = TickW'(read_sample_q);
      PH_RD_REC:    dur = TickW'(read_rec_q);
      PH_CONV:      dur = conv_wait_q;
      default:      dur = '0;
    endcase
    tick_nxt = tick_d + 1'b1;
    hit      = (tick_nxt >= dur);

    case (phase_d)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        line   = 1'b0;
        tick_d = hit ? '0 : tick_nxt;
        if (hit) phase_d = PH_RST_REL;
      end
      PH_RST_REL: begin
        tick_d = hit ? '0 : tick_nxt;
        if (hit) phase_d = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        // no presence check, just wait for the pull-up
        if (in_word_i.line_level) begin
          tick_d  = '0;
          phase_d = PH_RST_REC;
        end
      end
      PH_RST_REC: begin
        tick_d = hit ? '0 : tick_nxt;
        if (hit) sub_end = 1'b1;
      end
      PH_WR_SLOT: begin
        line   = 1'b0;
        tick_d = hit ? '0 : tick_nxt;
        if (hit) phase_d = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        line   = shift_d[0];
        tick_d = hit ? '0 : tick_nxt;
        if (hit) begin
          shift_d = {1'b0, shift_d[7:1]};
          bit_d   = bit_d + 1'b1;
          if (bit_d >= 4'd8) sub_end = 1'b1;
          else phase_d = PH_WR_SLOT;
        end
      end
      PH_RD_SLOT: begin
        line   = 1'b0;
        tick_d = hit ? '0 : tick_nxt;
        if (hit) phase_d = PH_RD_SAMPLE;
      end
      PH_RD_SAMPLE: begin
        tick_d = hit ? '0 : tick_nxt;
        if (hit) begin
          // lsb first, so new bits enter at the top
          shift_d = {in_word_i.line_level, shift_d[7:1]};
          phase_d = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        tick_d = hit ? '0 : tick_nxt;
        if (hit) begin
          bit_d = bit_d + 1'b1;
          if (bit_d >= 4'd8) sub_end = 1'b1;
          else phase_d = PH_RD_SLOT;
        end
      end
      PH_CONV: begin
        tick_d = hit ? '0 : tick_nxt;
        if (hit) sub_end = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase

    // end of one bus operation: capture data, advance the temp sequence
    if (sub_end) begin
      fin = 1'b1;
      if (active_d == CMD_READ) result_d = {8'h00, shift_d};
      if (active_d == CMD_TEMP) begin
        if (step_d == SEQ_LOW_BYTE) low_d = shift_d;
        if (step_d == SEQ_LAST) result_d = {shift_d, low_d};
        if (step_d < SEQ_LAST) begin
          fin    = 1'b0;
          step_d = step_d + 1'b1;
          kind   = seq_kind(step_d);
          kbyte  = seq_byte(step_d);
          tick_d = '0;
          bit_d  = '0;
          case (kind)
            KIND_RESET: phase_d = PH_RST_LOW;
            KIND_WRITE: begin
              shift_d = kbyte;
              phase_d = PH_WR_SLOT;
            end
            KIND_READ: begin
              shift_d = '0;
              phase_d = PH_RD_SLOT;
            end
            default: phase_d = PH_CONV;
          endcase
        end
      end
      if (fin) begin
        phase_d  = PH_IDLE;
        tick_d   = '0;
        bit_d    = '0;
        step_d   = '0;
        active_d = CMD_TICK;
        done     = 1'b1;
      end
    end

    out_word_d.line_release = line;
    out_word_d.busy_res     = (phase_d != PH_IDLE);
    out_word_d.done_res     = done;
    out_word_d.read_value   = result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q   <= RESET_LOW_DEF;
      reset_rel_q   <= RESET_REL_DEF;
      pres_rec_q    <= PRES_RECOVER_DEF;
      slot_low_q    <= SLOT_LOW_DEF;
      write_hold_q  <= WRITE_HOLD_DEF;
      read_sample_q <= READ_SAMPLE_DEF;
      read_rec_q    <= READ_RECOVER_DEF;
      conv_wait_q   <= CONV_WAIT_DEF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESET_LOW:    reset_low_q   <= cfg_data_i[9:0];
        CFG_RESET_REL:    reset_rel_q   <= cfg_data_i[7:0];
        CFG_PRES_RECOVER: pres_rec_q    <= cfg_data_i[9:0];
        CFG_SLOT_LOW:     slot_low_q    <= cfg_data_i[3:0];
        CFG_WRITE_HOLD:   write_hold_q  <= cfg_data_i[7:0];
        CFG_READ_SAMPLE:  read_sample_q <= cfg_data_i[3:0];
        CFG_READ_RECOVER: read_rec_q    <= cfg_data_i[7:0];
        CFG_CONV_WAIT:    conv_wait_q   <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      step_q      <= '0;
      low_q       <= '0;
      result_q    <= '0;
      active_q    <= CMD_TICK;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (in_fire) begin
        phase_q    <= phase_d;
        tick_q     <= tick_d;
        bit_q      <= bit_d;
        shift_q    <= shift_d;
        step_q     <= step_d;
        low_q      <= low_d;
        result_q   <= result_d;
        active_q   <= active_d;
        out_word_q <= out_word_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

/* tb/tb_one_wire_temperature_master_core.sv */
`timescale 1ns / 1ps

module tb_one_wire_temperature_master_core
  import owtm_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 300000;
  // codes above the temperature read are undefined and must act as a plain tick
  localparam logic [2:0] CMD_CODE_MAX = 3'd7;

  // sequencer phases of the bus master, as the predictor tracks them
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_WR_SLOT,
    PH_WR_HOLD,
    PH_RD_SLOT,
    PH_RD_SAMPLE,
    PH_RD_REC,
    PH_CONV
  } bus_phase_e;

  // steps of the temperature read: reset, skip rom, convert, wait,
  // reset, skip rom, read scratchpad, low byte, high byte
  localparam kind_e TEMP_STEP_KIND [9] = '{
    KIND_RESET, KIND_WRITE, KIND_WRITE, KIND_CONV,
    KIND_RESET, KIND_WRITE, KIND_WRITE, KIND_READ, KIND_READ
  };
  localparam logic [7:0] TEMP_STEP_BYTE [9] = '{
    8'h00, ROM_SKIP, FN_CONVERT, 8'h00, 8'h00, ROM_SKIP, FN_READ_SCRAT, 8'h00, 8'h00
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_word;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_idx = CFG_RESET_LOW;
  logic [CfgDataW-1:0] cfg_data = '0;

  // idling controls, changed only between phases
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // predictor copy of the timing registers
  logic [9:0]  t_rst_low;
  logic [7:0]  t_rst_rel;
  logic [9:0]  t_pres_rec;
  logic [3:0]  t_slot_low;
  logic [7:0]  t_wr_hold;
  logic [3:0]  t_rd_sample;
  logic [7:0]  t_rd_rec;
  logic [19:0] t_conv;

  // predictor copy of the sequencer state
  bus_phase_e  bus_phase;
  logic [19:0] tick_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_reg;
  logic [3:0]  temp_step;
  logic [7:0]  temp_low;
  logic [15:0] read_result;
  logic [2:0]  active_cmd;

  out_word_t   bus_results_q[$];
  int unsigned fail_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned active_ticks = 0;
  int unsigned cmd_starts [5] = '{default: 0};
  int unsigned timing_sets = 0;
  int unsigned cycle_cnt = 0;

  one_wire_temperature_master_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // bus master predictor
  // ---------------------------------------------------------------------------

  function automatic void start_sub_op(kind_e kind, logic [7:0] value);
    tick_cnt = '0;
    bit_cnt = '0;
    case (kind)
      KIND_RESET: bus_phase = PH_RST_LOW;
      KIND_WRITE: begin
        shift_reg = value;
        bus_phase = PH_WR_SLOT;
      end
      KIND_READ: begin
        shift_reg = '0;
        bus_phase = PH_RD_SLOT;
      end
      default: bus_phase = PH_CONV;
    endcase
  endfunction

  // a sub-operation ended; returns 1 when the whole command is done
  function automatic bit end_sub_op();
    if (active_cmd == CMD_READ) read_result = {8'h00, shift_reg};
    if (active_cmd == CMD_TEMP) begin
      if (temp_step == SEQ_LOW_BYTE) temp_low = shift_reg;
      if (temp_step == SEQ_LAST) read_result = {shift_reg, temp_low};
      if (temp_step < SEQ_LAST) begin
        temp_step = temp_step + 1'b1;
        start_sub_op(TEMP_STEP_KIND[temp_step], TEMP_STEP_BYTE[temp_step]);
        return 1'b0;
      end
    end
    bus_phase = PH_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    temp_step = '0;
    active_cmd = CMD_TICK;
    return 1'b1;
  endfunction

  // one tick of a timed phase; a zero duration behaves as one tick
  function automatic bit phase_elapsed(logic [19:0] dur);
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= dur) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_bus_tick(in_word_t w);
    out_word_t r;
    logic      line;
    bit        done;
    line = 1'b1;
    done = 1'b0;
    // commands are only taken when idle; codes above the temperature read are ignored
    if (bus_phase == PH_IDLE && w.command >= CMD_RESET && w.command <= CMD_TEMP) begin
      active_cmd = w.command;
      temp_step = '0;
      cmd_starts[w.command]++;
      case (w.command)
        CMD_RESET: start_sub_op(KIND_RESET, 8'h00);
        CMD_WRITE: start_sub_op(KIND_WRITE, w.write_data);
        CMD_READ:  start_sub_op(KIND_READ, 8'h00);
        default:   start_sub_op(TEMP_STEP_KIND[0], TEMP_STEP_BYTE[0]);
      endcase
    end
    case (bus_phase)
      PH_RST_LOW: begin
        line = 1'b0;
        if (phase_elapsed(t_rst_low)) bus_phase = PH_RST_REL;
      end
      PH_RST_REL: if (phase_elapsed(t_rst_rel)) bus_phase = PH_RST_WAIT;
      PH_RST_WAIT: begin
        // no presence check, just wait for the pull-up
        if (w.line_level) begin
          tick_cnt = '0;
          bus_phase = PH_RST_REC;
        end
      end
      PH_RST_REC: if (phase_elapsed(t_pres_rec)) done = end_sub_op();
      PH_WR_SLOT: begin
        line = 1'b0;
        if (phase_elapsed(t_slot_low)) bus_phase = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        line = shift_reg[0];
        if (phase_elapsed(t_wr_hold)) begin
          shift_reg = shift_reg >> 1;
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= 4'd8) done = end_sub_op();
          else bus_phase = PH_WR_SLOT;
        end
      end
      PH_RD_SLOT: begin
        line = 1'b0;
        if (phase_elapsed(t_slot_low)) bus_phase = PH_RD_SAMPLE;
      end
      PH_RD_SAMPLE: begin
        if (phase_elapsed(t_rd_sample)) begin
          shift_reg = {w.line_level, shift_reg[7:1]};
          bus_phase = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        if (phase_elapsed(t_rd_rec)) begin
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= 4'd8) done = end_sub_op();
          else bus_phase = PH_RD_SLOT;
        end
      end
      PH_CONV: if (phase_elapsed(t_conv)) done = end_sub_op();
      default: bus_phase = PH_IDLE;
    endcase
    r.line_release = line;
    r.busy_res = (bus_phase != PH_IDLE);
    r.done_res = done;
    r.read_value = read_result;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving, receiving and checking
  // ---------------------------------------------------------------------------

  // present one tick word; gaps are inserted before it at random
  task automatic send_bus_tick(input logic [2:0] cmd, input logic [7:0] data, input logic lvl);
    in_word_t  w;
    out_word_t predicted;
    w.command = cmd;
    w.write_data = data;
    w.line_level = lvl;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predicted = predict_bus_tick(w);
    bus_results_q.push_back(predicted);
    if (predicted.busy_res || predicted.done_res) active_ticks++;
  endtask

  // start a command and keep ticking until the predictor says idle
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] data,
                             input int unsigned high_pct, input bit noisy);
    logic [2:0] c;
    send_bus_tick(cmd, data, $urandom_range(99) < high_pct);
    while (bus_phase != PH_IDLE) begin
      // noisy runs throw stray commands at the busy block
      c = (noisy && $urandom_range(99) < 10) ? 3'($urandom_range(CMD_CODE_MAX)) : CMD_TICK;
      send_bus_tick(c, 8'($urandom), $urandom_range(99) < high_pct);
    end
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [2:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      CFG_RESET_LOW:    t_rst_low = value[9:0];
      CFG_RESET_REL:    t_rst_rel = value[7:0];
      CFG_PRES_RECOVER: t_pres_rec = value[9:0];
      CFG_SLOT_LOW:     t_slot_low = value[3:0];
      CFG_WRITE_HOLD:   t_wr_hold = value[7:0];
      CFG_READ_SAMPLE:  t_rd_sample = value[3:0];
      CFG_READ_RECOVER: t_rd_rec = value[7:0];
      default:          t_conv = value;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // writes every timing register; called only with the block idle and drained
  task automatic load_timings(input logic [19:0] rst_low, input logic [19:0] rst_rel,
                              input logic [19:0] pres_rec, input logic [19:0] slot_low,
                              input logic [19:0] wr_hold, input logic [19:0] rd_sample,
                              input logic [19:0] rd_rec, input logic [19:0] conv);
    write_timing(CFG_RESET_LOW, rst_low);
    write_timing(CFG_RESET_REL, rst_rel);
    write_timing(CFG_PRES_RECOVER, pres_rec);
    write_timing(CFG_SLOT_LOW, slot_low);
    write_timing(CFG_WRITE_HOLD, wr_hold);
    write_timing(CFG_READ_SAMPLE, rd_sample);
    write_timing(CFG_READ_RECOVER, rd_rec);
    write_timing(CFG_CONV_WAIT, conv);
    timing_sets++;
  endtask

  // small value with junk above the register width, which the block must drop
  function automatic logic [19:0] with_junk(int unsigned width, int unsigned value);
    return (20'($urandom) << width) | 20'(value);
  endfunction

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // each word taken from the output is held against the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (bus_results_q.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_word);
        fail_cnt++;
      end else begin
        want = bus_results_q.pop_front();
        check_field("line_release", 16'(want.line_release), 16'(out_word.line_release));
        check_field("busy_res", 16'(want.busy_res), 16'(out_word.busy_res));
        check_field("done_res", 16'(want.done_res), 16'(out_word.done_res));
        check_field("read_value", want.read_value, out_word.read_value);
        checked_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of the slot timing: one byte write
  task automatic test_default_timing();
    run_command(CMD_WRITE, 8'h5A, 50, 1'b0);
    drain_results();
  endtask

  // all registers zero behave as one-tick phases; byte and line extremes
  task automatic test_zero_timing();
    load_timings('0, '0, '0, '0, '0, '0, '0, '0);
    run_command(CMD_RESET, 8'h00, 100, 1'b0);
    run_command(CMD_WRITE, 8'h00, 50, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 50, 1'b0);
    run_command(CMD_READ, 8'h00, 100, 1'b0);
    run_command(CMD_READ, 8'h00, 0, 1'b0);
    run_command(CMD_READ, 8'h00, 50, 1'b0);
    run_command(CMD_TEMP, 8'h00, 50, 1'b0);
    drain_results();
  endtask

  // the narrow slot registers at their widest; the wide ones are too long to run through
  task automatic test_max_timing();
    load_timings(20'd1, 20'd1, 20'd1, '1, 20'd1, '1, 20'd1, 20'd1);
    run_command(CMD_WRITE, 8'hA5, 50, 1'b0);
    run_command(CMD_READ, 8'h00, 50, 1'b0);
    drain_results();
  endtask

  // undefined codes while idle, and every code thrown at a busy block
  task automatic test_ignored_commands();
    load_timings(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
    send_bus_tick(CMD_TICK, 8'hFF, 1'b1);
    for (int c = CMD_TEMP + 1; c <= CMD_CODE_MAX; c++) begin
      send_bus_tick(3'(c), 8'hFF, 1'b0);
      send_bus_tick(3'(c), 8'h00, 1'b1);
    end
    send_bus_tick(CMD_READ, 8'h00, 1'b1);
    for (int c = CMD_RESET; c <= CMD_CODE_MAX; c++) send_bus_tick(3'(c), 8'($urandom), 1'b1);
    while (bus_phase != PH_IDLE) send_bus_tick(CMD_TICK, 8'h00, 1'b1);
    run_command(CMD_WRITE, 8'h3C, 50, 1'b1);
    drain_results();
  endtask

  // line held low after the reset release: the master must keep waiting
  task automatic test_stuck_line();
    send_bus_tick(CMD_RESET, 8'h00, 1'b0);
    while (bus_phase != PH_RST_WAIT) send_bus_tick(CMD_TICK, 8'($urandom), 1'b0);
    repeat (150) send_bus_tick(CMD_TICK, 8'($urandom), 1'b0);
    while (bus_phase != PH_IDLE) send_bus_tick(CMD_TICK, 8'($urandom), 1'b1);
    drain_results();
  endtask

  // mostly well-formed commands with random bytes and line levels, some noise
  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned n_words);
    int unsigned first;
    int unsigned r;
    logic [2:0]  c;
    load_timings(with_junk(10, $urandom_range(6)), with_junk(8, $urandom_range(4)),
                 with_junk(10, $urandom_range(6)), with_junk(4, $urandom_range(3)),
                 with_junk(8, $urandom_range(4)), with_junk(4, $urandom_range(3)),
                 with_junk(8, $urandom_range(4)), 20'($urandom_range(30)));
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    first = active_ticks;
    while (active_ticks - first < n_words) begin
      r = $urandom_range(99);
      if (r < 6) begin
        c = 3'($urandom_range(CMD_TEMP + 1, CMD_CODE_MAX + 1));
        if (c == CMD_TICK) c = CMD_TICK;
      end
      else if (r < 20) c = CMD_RESET;
      else if (r < 48) c = CMD_WRITE;
      else if (r < 76) c = CMD_READ;
      else c = CMD_TEMP;
      run_command(c, 8'($urandom), 50, 1'b1);
    end
    drain_results();
    send_gap_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    t_rst_low = RESET_LOW_DEF;
    t_rst_rel = RESET_REL_DEF;
    t_pres_rec = PRES_RECOVER_DEF;
    t_slot_low = SLOT_LOW_DEF;
    t_wr_hold = WRITE_HOLD_DEF;
    t_rd_sample = READ_SAMPLE_DEF;
    t_rd_rec = READ_RECOVER_DEF;
    t_conv = CONV_WAIT_DEF;
    bus_phase = PH_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    shift_reg = '0;
    temp_step = '0;
    temp_low = '0;
    read_result = '0;
    active_cmd = CMD_TICK;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_timing();
    test_zero_timing();
    test_max_timing();
    test_ignored_commands();
    test_stuck_line();
    test_random_traffic(21, 65, 130);
    test_random_traffic(65, 21, 130);
    test_random_traffic(0, 0, 130);

    // the output stage is one register deep; the spare wait catches any stray word
    repeat (5) @(posedge clk_i);
    if (bus_results_q.size() != 0) begin
      $error("%0d predicted words never arrived", bus_results_q.size());
      fail_cnt++;
    end

    $display("checked %0d result words from %0d bus resets, %0d byte writes, %0d byte reads,",
             checked_cnt, cmd_starts[CMD_RESET], cmd_starts[CMD_WRITE], cmd_starts[CMD_READ]);
    $display("%0d temperature reads under %0d timing register sets",
             cmd_starts[CMD_TEMP], timing_sets);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
